[sv/csd_pkg.sv]
`timescale 1ns / 1ps
// Package for the chain sorter: sizes, the cell control struct and the
// point normalization function. No dependencies.
package csd_pkg;

    localparam int MAX_CHAINS  = 64;
    localparam int POINT_CHARS = 6;
    localparam int POINT_W     = 8 * POINT_CHARS;
    localparam int KEY_W       = 2 * POINT_W;
    localparam int CNT_W       = $clog2(MAX_CHAINS + 1);

    typedef logic [POINT_W-1:0] t_point;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [CNT_W-1:0]   t_count;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

    // Clear the first NUL byte and every byte after it.
    function automatic t_point normalize_point(input t_point p);
        t_point r;
        logic   cut;
        r   = '0;
        cut = 1'b0;
        for (int i = 0; i < POINT_CHARS; i++) begin
            if (p[POINT_W-1-8*i -: 8] == 8'h00) begin
                cut = 1'b1;
            end
            if (!cut) begin
                r[POINT_W-1-8*i -: 8] = p[POINT_W-1-8*i -: 8];
            end
        end
        return r;
    endfunction

endpackage

[sv/csd_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for chain input and result output.
// Depends on csd_pkg.
interface csd_in_if;
    import csd_pkg::*;
    logic   valid;
    logic   ready;
    t_point start_point;
    t_point end_point;
    logic   last_entry;

    modport source (output valid, output start_point, output end_point,
                    output last_entry, input ready);
    modport sink   (input valid, input start_point, input end_point,
                    input last_entry, output ready);
endinterface

interface csd_out_if;
    import csd_pkg::*;
    logic   valid;
    logic   ready;
    t_point start_out;
    t_point end_out;
    logic   last_out;
    logic   dropped_flag;

    modport source (output valid, output start_out, output end_out,
                    output last_out, output dropped_flag, input ready);
    modport sink   (input valid, input start_out, input end_out,
                    input last_out, input dropped_flag, output ready);
endinterface

[sv/csd_cell.sv]
`timescale 1ns / 1ps
// One cell of the insertion sort chain: holds one key {end, start}.
// Depends on csd_pkg.
module csd_cell
    import csd_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_key      i_new_key,
    input  logic      i_valid,
    input  t_key      i_left_key,
    input  logic      i_left_less,
    input  t_key      i_right_key,
    output t_key      o_key,
    output logic      o_less
);

    t_key r_key;
    t_key n_key;

    assign o_key  = r_key;
    assign o_less = !i_valid || (i_new_key < r_key);

    always_comb begin
        n_key = r_key;
        if (i_ctl.insert) begin
            if (i_left_less) begin
                n_key = i_left_key;
            end else if (o_less) begin
                n_key = i_new_key;
            end
        end else if (i_ctl.shift) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

[sv/chain_sort_dedupe_by_endpoint.sv]
`timescale 1ns / 1ps
// Top level: chain of sort cells, load/drain control, dedupe and output register.
// Depends on csd_pkg, csd_if and csd_cell.
//
// Channel | Dir | Payload                                       | Handshake
// i_in    | in  | start_point, end_point, last_entry           | valid/ready
// o_out   | out | start_out, end_out, last_out, dropped_flag   | valid/ready
//
// Load: one chain per cycle; inserted into the sorted cell chain at once if not full.
// After the last chain, the drain shifts the stored chains out of the cell chain,
// one cell shift per cycle; input ready is low until the final result is registered.
// Output stalls hold the drain; reset (i_rst_n low, synchronous) empties the store.
module chain_sort_dedupe_by_endpoint
    import csd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    csd_in_if.sink    i_in,
    csd_out_if.source o_out
);

    localparam logic S_LOAD  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic   r_state;
    t_count r_count;
    logic   r_overflow;
    logic   r_cand_v;
    t_key   r_cand;
    logic   r_out_valid;
    t_point r_out_start;
    t_point r_out_end;
    logic   r_out_last;
    logic   r_out_drop;

    t_key      w_new_key;
    t_key      w_key  [MAX_CHAINS];
    logic      w_less [MAX_CHAINS];
    t_cell_ctl w_ctl;
    logic      w_accept;
    logic      w_full;
    logic      w_have_head;
    logic      w_slot_free;
    logic      w_pop;
    logic      w_push;
    logic      w_push_last;
    t_key      w_head;

    assign w_new_key = {normalize_point(i_in.end_point), normalize_point(i_in.start_point)};
    assign i_in.ready = (r_state == S_LOAD);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == t_count'(MAX_CHAINS));
    assign w_head      = w_key[0];
    assign w_have_head = (r_count != '0);
    assign w_slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        w_pop       = 1'b0;
        w_push      = 1'b0;
        w_push_last = 1'b0;
        if (r_state == S_DRAIN) begin
            if (w_have_head) begin
                if (!r_cand_v) begin
                    w_pop = 1'b1;
                end else if (w_head[KEY_W-1:POINT_W] == r_cand[KEY_W-1:POINT_W]) begin
                    w_pop = 1'b1;
                end else if (w_slot_free) begin
                    w_pop  = 1'b1;
                    w_push = 1'b1;
                end
            end else if (r_cand_v && w_slot_free) begin
                w_push      = 1'b1;
                w_push_last = 1'b1;
            end
        end
    end

    assign w_ctl.insert = w_accept && !w_full;
    assign w_ctl.shift  = w_pop;

    for (genvar g = 0; g < MAX_CHAINS; g++) begin : g_cell
        t_key w_left_key;
        logic w_left_less;
        t_key w_right_key;
        if (g == 0) begin : g_first
            assign w_left_key  = w_new_key;
            assign w_left_less = 1'b0;
        end else begin : g_inner
            assign w_left_key  = w_key[g-1];
            assign w_left_less = w_less[g-1];
        end
        if (g == MAX_CHAINS - 1) begin : g_end
            assign w_right_key = '0;
        end else begin : g_mid
            assign w_right_key = w_key[g+1];
        end
        csd_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_new_key   (w_new_key),
            .i_valid     (t_count'(g) < r_count),
            .i_left_key  (w_left_key),
            .i_left_less (w_left_less),
            .i_right_key (w_right_key),
            .o_key       (w_key[g]),
            .o_less      (w_less[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_cand_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctl.insert) begin
                r_count <= r_count + t_count'(1);
            end else if (w_pop) begin
                r_count <= r_count - t_count'(1);
            end
            if (w_accept && w_full) begin
                r_overflow <= 1'b1;
            end
            if (w_accept && i_in.last_entry) begin
                r_state <= S_DRAIN;
            end
            if (w_pop) begin
                r_cand_v <= 1'b1;
            end
            if (w_push_last) begin
                r_cand_v   <= 1'b0;
                r_overflow <= 1'b0;
                r_state    <= S_LOAD;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && (!r_cand_v || w_push)) begin
            r_cand <= w_head;
        end
        if (w_push) begin
            r_out_start <= r_cand[POINT_W-1:0];
            r_out_end   <= r_cand[KEY_W-1:POINT_W];
            r_out_last  <= w_push_last;
            r_out_drop  <= r_overflow;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.start_out    = r_out_start;
    assign o_out.end_out      = r_out_end;
    assign o_out.last_out     = r_out_last;
    assign o_out.dropped_flag = r_out_drop;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(MAX_CHAINS))
        else $error("chain count above capacity");

    a_load_no_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !r_cand_v)
        else $error("candidate left over while loading");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && r_cand_v && w_have_head) |-> !(w_head < r_cand))
        else $error("drained chains out of order");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_last |=> (r_state == S_LOAD) && r_out_valid && r_out_last)
        else $error("final result did not end the run");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Testbench for chain_sort_dedupe_by_endpoint: random chain loads against a sorting,
// deduplicating scoreboard. Depends on csd_pkg, csd_if and the block itself.
module testbench;
    import csd_pkg::*;

    typedef struct packed {
        t_point start_pt;
        t_point end_pt;
        logic   last;
        logic   dropped;
    } t_chain_result;

    class chain_scoreboard;
        t_key          loaded_keys[$];
        logic          overflow;
        t_chain_result expected_q[$];
        int            errors;
        int            loads;
        int            chains;
        int            overflow_loads;
        int            results_seen;

        function new();
            overflow       = 1'b0;
            errors         = 0;
            loads          = 0;
            chains         = 0;
            overflow_loads = 0;
            results_seen   = 0;
        endfunction

        function t_point cut_at_nul(t_point p);
            t_point r;
            bit     seen_nul;
            r        = '0;
            seen_nul = 1'b0;
            for (int b = POINT_CHARS - 1; b >= 0; b--) begin
                if (p[8*b +: 8] == 8'h00) begin
                    seen_nul = 1'b1;
                end
                if (!seen_nul) begin
                    r[8*b +: 8] = p[8*b +: 8];
                end
            end
            return r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_chain(t_point s, t_point e, logic last);
            t_key          k;
            t_point        final_end;
            int            j;
            int            n;
            t_chain_result r;
            chains++;
            if (loaded_keys.size() < MAX_CHAINS) begin
                k = {cut_at_nul(e), cut_at_nul(s)};
                loaded_keys.insert(loaded_keys.size(), k);
            end else begin
                overflow = 1'b1;
            end
            if (!last) begin
                return;
            end
            n = loaded_keys.size();
            // sort ascending by end point, then start point
            for (int i = 1; i < n; i++) begin
                k = loaded_keys[i];
                j = i;
                while (j > 0 && loaded_keys[j-1] > k) begin
                    loaded_keys[j] = loaded_keys[j-1];
                    j--;
                end
                loaded_keys[j] = k;
            end
            final_end = loaded_keys[n-1][KEY_W-1:POINT_W];
            for (int i = 0; i < n; i++) begin
                if (i == 0 || loaded_keys[i][KEY_W-1:POINT_W] != loaded_keys[i-1][KEY_W-1:POINT_W])
                begin
                    r.start_pt = loaded_keys[i][POINT_W-1:0];
                    r.end_pt   = loaded_keys[i][KEY_W-1:POINT_W];
                    r.last     = (r.end_pt == final_end);
                    r.dropped  = overflow;
                    expected_q.insert(expected_q.size(), r);
                end
            end
            loads++;
            if (overflow) begin
                overflow_loads++;
            end
            loaded_keys.delete();
            overflow = 1'b0;
        endfunction

        function void check_result(t_point s, t_point e, logic last, logic dropped);
            t_chain_result x;
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("unexpected result: start_out %h end_out %h", s, e);
                errors++;
                return;
            end
            x = expected_q.pop_front();
            if (s !== x.start_pt) begin
                $error("start_out: expected %h, actual %h", x.start_pt, s);
                errors++;
            end
            if (e !== x.end_pt) begin
                $error("end_out: expected %h, actual %h", x.end_pt, e);
                errors++;
            end
            if (last !== x.last) begin
                $error("last_out: expected %b, actual %b", x.last, last);
                errors++;
            end
            if (dropped !== x.dropped) begin
                $error("dropped_flag: expected %b, actual %b", x.dropped, dropped);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    csd_in_if  in_ch ();
    csd_out_if out_ch ();

    chain_scoreboard sb;

    bit in_idle;
    bit out_idle;
    int hold_len;
    int items_sent;

    chain_sort_dedupe_by_endpoint dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_400_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_chain(in_ch.start_point, in_ch.end_point, in_ch.last_entry);
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.start_out, out_ch.end_out, out_ch.last_out,
                                out_ch.dropped_flag);
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = out_idle ? $urandom_range(0, 6) : 0;
            if (hold_len > 0) begin
                stall    = hold_len;
                hold_len = 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready) && hold_len == 0);
        end
    end

    function automatic t_point txt(input string str);
        t_point p;
        p = '0;
        for (int i = 0; i < str.len() && i < POINT_CHARS; i++) begin
            p[POINT_W-1-8*i -: 8] = str[i];
        end
        return p;
    endfunction

    function automatic t_point rand_point();
        t_point p;
        int     len;
        p = '0;
        case ($urandom_range(0, 3))
            0: begin
                p[47:16] = $urandom;
                p[15:0]  = 16'($urandom);
            end
            1: begin
                // short text from a tiny alphabet to force collisions
                len = $urandom_range(0, POINT_CHARS);
                for (int i = 0; i < len; i++) begin
                    p[POINT_W-1-8*i -: 8] = 8'(8'h61 + $urandom_range(0, 2));
                end
            end
            2: begin
                // text, a NUL, then junk that must be ignored
                len = $urandom_range(0, POINT_CHARS - 1);
                for (int i = 0; i < POINT_CHARS; i++) begin
                    if (i < len) begin
                        p[POINT_W-1-8*i -: 8] = 8'(8'h61 + $urandom_range(0, 2));
                    end else if (i > len) begin
                        p[POINT_W-1-8*i -: 8] = 8'($urandom_range(0, 255));
                    end
                end
            end
            default: begin
                len = $urandom_range(1, POINT_CHARS);
                for (int i = 0; i < len; i++) begin
                    p[POINT_W-1-8*i -: 8] = 8'($urandom_range(8'h21, 8'h7E));
                end
            end
        endcase
        return p;
    endfunction

    task automatic send_chain(input t_point s, input t_point e, input logic last);
        int gap;
        gap = in_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.start_point <= s;
        in_ch.end_point   <= e;
        in_ch.last_entry  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_random_run(input int len);
        t_point ends_seen[$];
        t_point s;
        t_point e;
        t_point prev_s;
        t_point prev_e;
        prev_s = '0;
        prev_e = '0;
        for (int i = 0; i < len; i++) begin
            s = rand_point();
            if (ends_seen.size() > 0 && $urandom_range(0, 9) < 4) begin
                e = ends_seen[$urandom_range(0, ends_seen.size() - 1)];
            end else begin
                e = rand_point();
                ends_seen.insert(ends_seen.size(), e);
            end
            if (i > 0 && $urandom_range(0, 9) == 0) begin
                s = prev_s;
                e = prev_e;
            end
            send_chain(s, e, i == len - 1);
            prev_s = s;
            prev_e = e;
        end
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int run_idx;
        int len;
        sb         = new();
        in_idle    = 1'b1;
        out_idle   = 1'b1;
        hold_len   = 0;
        items_sent = 0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.start_point <= '0;
        in_ch.end_point   <= '0;
        in_ch.last_entry  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_chain('1, '1, 1'b1);
        send_chain('0, '0, 1'b1);

        send_chain(txt("zeta"),       txt("end2"),       1'b0);
        send_chain(txt("alpha"),      txt("end1"),       1'b0);
        send_chain(48'h626574610041,  txt("end1"),       1'b0);
        send_chain(txt("alpha"),      txt("end1"),       1'b0);
        send_chain(txt("aa"),         48'h656E643100FF,  1'b0);
        send_chain(48'h00FFFFFFFFFF,  txt("end0"),       1'b1);

        send_chain(txt("q"), 48'h004142434445, 1'b0);
        send_chain(txt("q"), 48'h004142434445, 1'b0);
        send_chain(txt("q"), '0,               1'b1);

        send_chain(txt("b"), txt("zz"), 1'b0);
        send_chain(txt("c"), txt("aa"), 1'b1);

        items_sent = 0;
        run_idx    = 0;
        while (items_sent < 300) begin
            if (run_idx == 0) begin
                len = MAX_CHAINS;
            end else if (run_idx == 1) begin
                len = MAX_CHAINS + 3;
            end else if ($urandom_range(0, 15) == 0) begin
                len = $urandom_range(MAX_CHAINS - 4, MAX_CHAINS + 6);
            end else begin
                len = $urandom_range(1, 12);
            end
            in_idle  = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);
            if (run_idx == 3) begin
                hold_len = 400;
            end
            if (run_idx == 6) begin
                in_ch.valid <= 1'b0;
                wait_drained();
                repeat (8) @(posedge i_clk);
            end
            send_random_run(len);
            run_idx++;
        end
        in_ch.valid <= 1'b0;

        wait_drained();
        repeat (2 * MAX_CHAINS + 20) @(posedge i_clk);

        $display("Ran %0d chain loads (%0d chains, %0d loads overflowed the store).",
                 sb.loads, sb.chains, sb.overflow_loads);
        $display("Checked %0d unique-end results.", sb.results_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
